// ===== hw/rtl/memory_value_scan_matcher_unit_macros.svh =====
// Assertion macros shared by the scan matcher RTL.
`ifndef MEMORY_VALUE_SCAN_MATCHER_UNIT_MACROS_SVH
`define MEMORY_VALUE_SCAN_MATCHER_UNIT_MACROS_SVH

// Same-cycle implication, clocked on i_clk, off during reset.
`define MVSM_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on i_clk, off during reset.
`define MVSM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/mvsm_pkg.sv =====
// Shared constants, codes, types and length decode for the scan matcher.
package mvsm_pkg;

    localparam int MAX_PATTERN_BYTES = 16;
    localparam int PAT_BYTES         = 16;
    localparam int ADDRESS_BITS      = 48;
    localparam int HIT_BYTES         = 8;
    localparam int LEN_LIMIT = (MAX_PATTERN_BYTES < PAT_BYTES) ? MAX_PATTERN_BYTES : PAT_BYTES;
    localparam int LEN_W     = $clog2(LEN_LIMIT + 1);
    localparam int FILL_W    = $clog2(MAX_PATTERN_BYTES + 1);
    localparam int ALIGN_W   = $clog2(LEN_LIMIT);
    localparam int WIN_IDX_W = $clog2(MAX_PATTERN_BYTES);
    localparam int PAT_IDX_W = $clog2(PAT_BYTES);
    localparam int CFG_IDX_W = 3;

    // value kinds
    localparam logic [3:0] KIND_U8     = 4'd0;
    localparam logic [3:0] KIND_I8     = 4'd1;
    localparam logic [3:0] KIND_U16    = 4'd2;
    localparam logic [3:0] KIND_I16    = 4'd3;
    localparam logic [3:0] KIND_U32    = 4'd4;
    localparam logic [3:0] KIND_I32    = 4'd5;
    localparam logic [3:0] KIND_U64    = 4'd6;
    localparam logic [3:0] KIND_I64    = 4'd7;
    localparam logic [3:0] KIND_F32    = 4'd8;
    localparam logic [3:0] KIND_F64    = 4'd9;
    localparam logic [3:0] KIND_BYTES  = 4'd10;
    localparam logic [3:0] KIND_STRING = 4'd11;

    // scan modes
    localparam logic [2:0] MODE_EXACT   = 3'd0;
    localparam logic [2:0] MODE_GREATER = 3'd1;
    localparam logic [2:0] MODE_LESS    = 3'd2;
    localparam logic [2:0] MODE_BETWEEN = 3'd3;
    localparam logic [2:0] MODE_UNKNOWN = 3'd4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_VALUE_KIND    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCAN_MODE     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MATCH_LENGTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_VALUE     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_VALUE    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_UPPER = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_MASK_LOWER    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_MASK_UPPER    = 3'd7;

    typedef logic [7:0] t_byte;

    typedef struct packed {
        logic [3:0]       kind;
        logic [2:0]       mode;
        logic [LEN_W-1:0] len;
        logic [63:0]      low;
        logic [63:0]      high;
    } t_eval_cfg;

    // Window length in bytes; zero for unused kinds.
    function automatic logic [LEN_W-1:0] active_length(input logic [3:0] kind,
                                                       input logic [4:0] mlen);
        logic [LEN_W-1:0] len;
        len = '0;
        unique case (kind) inside
            KIND_U8, KIND_I8:            len = LEN_W'(1);
            KIND_U16, KIND_I16:          len = LEN_W'(2);
            KIND_U32, KIND_I32, KIND_F32: len = LEN_W'(4);
            KIND_U64, KIND_I64, KIND_F64: len = LEN_W'(8);
            KIND_BYTES, KIND_STRING: begin
                if (int'(mlen) > LEN_LIMIT) len = LEN_W'(LEN_LIMIT);
                else len = LEN_W'(mlen);
            end
            default:                     len = '0;
        endcase
        return len;
    endfunction

endpackage

// ===== hw/rtl/mvsm_cell.sv =====
// One window cell: holds a byte and its readable flag, compares against a pattern byte.
module mvsm_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_shift,
    input  logic           i_clear,
    input  mvsm_pkg::t_byte i_byte,
    input  logic           i_readable,
    input  mvsm_pkg::t_byte i_pat_byte,
    input  mvsm_pkg::t_byte i_care_mask,
    output mvsm_pkg::t_byte o_byte,
    output logic           o_readable,
    output logic           o_equal
);

    mvsm_pkg::t_byte r_byte;
    mvsm_pkg::t_byte n_byte;
    logic            r_readable;
    logic            n_readable;

    // region start empties the cell before the shift lands
    assign n_byte     = i_clear ? '0 : i_byte;
    assign n_readable = i_readable && !i_clear;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_readable <= 1'b0;
        end else if (i_shift) begin
            r_readable <= n_readable;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_byte <= n_byte;
        end
    end

    assign o_byte     = r_byte;
    assign o_readable = r_readable;
    assign o_equal    = ((r_byte ^ i_pat_byte) & i_care_mask) == '0;

endmodule

// ===== hw/rtl/mvsm_eval.sv =====
// Window evaluation: typed value compares, pattern reduction and the hit decision.
module mvsm_eval (
    input  mvsm_pkg::t_eval_cfg                                i_cfg,
    input  mvsm_pkg::t_byte [mvsm_pkg::MAX_PATTERN_BYTES-1:0]  i_win_bytes,
    input  logic [mvsm_pkg::MAX_PATTERN_BYTES-1:0]             i_win_readable,
    input  logic [mvsm_pkg::MAX_PATTERN_BYTES-1:0]             i_cell_equal,
    input  logic [mvsm_pkg::FILL_W-1:0]                        i_fill,
    input  logic [mvsm_pkg::ALIGN_W-1:0]                       i_align,
    output logic                                               o_hit,
    output logic [63:0]                                        o_value
);

    logic [63:0] val;
    logic [63:0] wm;
    logic [63:0] sbit;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] kc;
    logic [63:0] kl;
    logic [63:0] kh;
    logic [mvsm_pkg::MAX_PATTERN_BYTES-1:0] beyond;
    logic        is_pat;
    logic        sgn;
    logic        flt;
    logic        is64;
    logic        nan_c, nan_l, nan_h;
    logic        zer_c, zer_l, zer_h;
    logic        lt_lc, lt_cl, le_ch, eq_cl;
    logic        f_ok_cl, f_ok_ch;
    logic        num_ok;
    logic        pat_ok;
    logic        match;
    logic        rd_first;
    logic        filled;

    function automatic logic f_nan(input logic [63:0] v, input logic wide);
        if (wide) return (&v[62:52]) && (|v[51:0]);
        return (&v[30:23]) && (|v[22:0]);
    endfunction

    function automatic logic f_zero(input logic [63:0] v, input logic [63:0] s,
                                    input logic [63:0] m);
        return (v & ~s & m) == '0;
    endfunction

    // monotone key: flip sign for ints, sign-magnitude to offset order for floats
    function automatic logic [63:0] f_key(input logic [63:0] v, input logic [63:0] s,
                                          input logic [63:0] m);
        return ((v & s) != '0) ? (~v & m) : (v | s);
    endfunction

    // first eight window bytes, little endian, and the width mask
    always_comb begin
        val = '0;
        wm  = '0;
        for (int k = 0; k < mvsm_pkg::HIT_BYTES; k++) begin
            if (k < int'(i_cfg.len)) begin
                val[8*k +: 8] = i_win_bytes[mvsm_pkg::WIN_IDX_W'(8'(i_cfg.len) - 8'(k + 1))];
                wm[8*k +: 8]  = 8'hFF;
            end
        end
    end

    assign sbit = wm ^ (wm >> 1);

    assign is_pat = (i_cfg.kind == mvsm_pkg::KIND_BYTES) || (i_cfg.kind == mvsm_pkg::KIND_STRING);
    assign sgn    = (i_cfg.kind == mvsm_pkg::KIND_I8)  || (i_cfg.kind == mvsm_pkg::KIND_I16) ||
                    (i_cfg.kind == mvsm_pkg::KIND_I32) || (i_cfg.kind == mvsm_pkg::KIND_I64);
    assign flt    = (i_cfg.kind == mvsm_pkg::KIND_F32) || (i_cfg.kind == mvsm_pkg::KIND_F64);
    assign is64   = i_cfg.kind == mvsm_pkg::KIND_F64;

    assign lo = i_cfg.low & wm;
    // unsigned kinds keep the full 64-bit upper bound
    assign hi = (sgn || flt) ? (i_cfg.high & wm) : i_cfg.high;

    assign nan_c = f_nan(val, is64);
    assign nan_l = f_nan(lo, is64);
    assign nan_h = f_nan(hi, is64);
    assign zer_c = f_zero(val, sbit, wm);
    assign zer_l = f_zero(lo, sbit, wm);
    assign zer_h = f_zero(hi, sbit, wm);

    assign kc = flt ? f_key(val, sbit, wm) : (sgn ? (val ^ sbit) : val);
    assign kl = flt ? f_key(lo, sbit, wm)  : (sgn ? (lo ^ sbit) : lo);
    assign kh = flt ? f_key(hi, sbit, wm)  : (sgn ? (hi ^ sbit) : hi);

    assign lt_lc = kl < kc;
    assign lt_cl = kc < kl;
    assign le_ch = kc <= kh;
    assign eq_cl = kc == kl;

    assign f_ok_cl = !nan_c && !nan_l;
    assign f_ok_ch = !nan_c && !nan_h;

    always_comb begin
        num_ok = 1'b0;
        if (flt) begin
            case (i_cfg.mode)
                mvsm_pkg::MODE_EXACT:   num_ok = f_ok_cl && (eq_cl || (zer_c && zer_l));
                mvsm_pkg::MODE_GREATER: num_ok = f_ok_cl && !(zer_c && zer_l) && lt_lc;
                mvsm_pkg::MODE_LESS:    num_ok = f_ok_cl && !(zer_c && zer_l) && lt_cl;
                default: begin
                    num_ok = f_ok_cl && (lt_lc || eq_cl || (zer_c && zer_l)) &&
                             f_ok_ch && (le_ch || (zer_c && zer_h));
                end
            endcase
        end else begin
            case (i_cfg.mode)
                mvsm_pkg::MODE_EXACT:   num_ok = eq_cl;
                mvsm_pkg::MODE_GREATER: num_ok = lt_lc;
                mvsm_pkg::MODE_LESS:    num_ok = lt_cl;
                default:                num_ok = !lt_cl && le_ch;
            endcase
        end
    end

    // cells past the window length do not vote
    always_comb begin
        for (int j = 0; j < mvsm_pkg::MAX_PATTERN_BYTES; j++) begin
            beyond[j] = j >= int'(i_cfg.len);
        end
    end

    assign pat_ok   = &(i_cell_equal | beyond);
    assign match    = is_pat ? pat_ok : num_ok;
    assign rd_first = i_win_readable[mvsm_pkg::WIN_IDX_W'(8'(i_cfg.len) - 8'd1)];
    assign filled   = 8'(i_fill) >= 8'(i_cfg.len);

    assign o_hit = (i_cfg.len != '0) && filled && rd_first &&
                   (i_cfg.mode <= mvsm_pkg::MODE_UNKNOWN) &&
                   ((i_cfg.mode == mvsm_pkg::MODE_UNKNOWN) ? (i_align == '0) : match);
    assign o_value = val;

endmodule

// ===== hw/rtl/memory_value_scan_matcher_unit.sv =====
// Top level of the memory value scanner: config registers, cell chain, eval and output stage.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+-------------------------------------------------
//  input    | i_in_valid / o_in_stall    | i_byte_value, i_byte_address, i_byte_readable,
//           |                            | i_region_first
//  result   | o_out_valid / i_out_stall  | o_hit_address, o_hit_value
//  config   | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
//  One item per cycle while o_in_stall is low: the cell chain shifts on accept, the next cycle
//  evaluates the window, and a hit loads the output register once that register is free.
//  Synchronous active-low reset restores register defaults and empties the window.
//  o_in_stall rises only when a hit waits in the eval stage behind a stalled output register.
//  o_cfg_ready is always high.
`include "memory_value_scan_matcher_unit_macros.svh"

module memory_value_scan_matcher_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [7:0]                          i_byte_value,
    input  logic [mvsm_pkg::ADDRESS_BITS-1:0]   i_byte_address,
    input  logic                                i_byte_readable,
    input  logic                                i_region_first,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [mvsm_pkg::ADDRESS_BITS-1:0]   o_hit_address,
    output logic [63:0]                         o_hit_value,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [mvsm_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [63:0]                         i_cfg_data
);

    localparam int MAXB = mvsm_pkg::MAX_PATTERN_BYTES;

    logic [3:0]  r_value_kind;
    logic [2:0]  r_scan_mode;
    logic [4:0]  r_match_length;
    logic [63:0] r_low_value;
    logic [63:0] r_high_value;
    logic [63:0] r_pattern_upper;
    logic [63:0] r_mask_lower;
    logic [63:0] r_mask_upper;

    logic [mvsm_pkg::FILL_W-1:0]       r_fill;
    logic [mvsm_pkg::FILL_W-1:0]       n_fill;
    logic [mvsm_pkg::FILL_W-1:0]       fill_base;
    logic [mvsm_pkg::ALIGN_W-1:0]      r_align;
    logic [mvsm_pkg::ALIGN_W-1:0]      n_align;
    logic [mvsm_pkg::ALIGN_W-1:0]      align_base;
    logic [7:0]                        align_step;
    logic [mvsm_pkg::ADDRESS_BITS-1:0] r_addr;
    logic                              r_eval_valid;
    logic                              n_eval_valid;
    logic                              r_out_valid;
    logic [mvsm_pkg::ADDRESS_BITS-1:0] r_hit_address;
    logic [63:0]                       r_hit_value;

    logic [mvsm_pkg::LEN_W-1:0]        len;
    logic                              in_acc;
    logic                              out_free;
    logic                              out_load;
    logic                              ev_hit;
    logic [63:0]                       ev_value;
    mvsm_pkg::t_eval_cfg               eval_cfg;

    logic [8*mvsm_pkg::PAT_BYTES-1:0]  pat_all;
    logic [8*mvsm_pkg::PAT_BYTES-1:0]  mask_all;
    mvsm_pkg::t_byte [MAXB-1:0]        cell_byte;
    logic [MAXB-1:0]                   cell_rd;
    logic [MAXB-1:0]                   cell_eq;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_value_kind    <= mvsm_pkg::KIND_U32;
            r_scan_mode     <= mvsm_pkg::MODE_EXACT;
            r_match_length  <= 5'd4;
            r_low_value     <= '0;
            r_high_value    <= '0;
            r_pattern_upper <= '0;
            r_mask_lower    <= '1;
            r_mask_upper    <= '1;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                mvsm_pkg::REG_VALUE_KIND:    r_value_kind    <= i_cfg_data[3:0];
                mvsm_pkg::REG_SCAN_MODE:     r_scan_mode     <= i_cfg_data[2:0];
                mvsm_pkg::REG_MATCH_LENGTH:  r_match_length  <= i_cfg_data[4:0];
                mvsm_pkg::REG_LOW_VALUE:     r_low_value     <= i_cfg_data;
                mvsm_pkg::REG_HIGH_VALUE:    r_high_value    <= i_cfg_data;
                mvsm_pkg::REG_PATTERN_UPPER: r_pattern_upper <= i_cfg_data;
                mvsm_pkg::REG_MASK_LOWER:    r_mask_lower    <= i_cfg_data;
                mvsm_pkg::REG_MASK_UPPER:    r_mask_upper    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    assign len      = mvsm_pkg::active_length(r_value_kind, r_match_length);
    assign pat_all  = {r_pattern_upper, r_low_value};
    assign mask_all = {r_mask_upper, r_mask_lower};

    // handshake
    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_eval_valid && ev_hit && !out_free;
    assign out_load   = r_eval_valid && ev_hit && out_free;
    assign in_acc     = i_in_valid && !o_in_stall;

    // cell j holds window byte j and faces pattern byte len-1-j
    for (genvar j = 0; j < MAXB; j++) begin : g_cell
        logic [7:0]                     pidx_full;
        logic [mvsm_pkg::PAT_IDX_W-1:0] pidx;
        mvsm_pkg::t_byte                pat_byte;
        mvsm_pkg::t_byte                care;
        mvsm_pkg::t_byte                in_byte;
        logic                           in_rd;
        logic                           in_clear;

        assign pidx_full = 8'(len) - 8'd1 - 8'(j);
        assign pidx      = pidx_full[mvsm_pkg::PAT_IDX_W-1:0];
        assign pat_byte  = pat_all[8*pidx +: 8];
        assign care      = (r_value_kind == mvsm_pkg::KIND_STRING) ? 8'hFF : mask_all[8*pidx +: 8];

        if (j == 0) begin : g_head
            assign in_byte  = i_byte_value;
            assign in_rd    = i_byte_readable;
            assign in_clear = 1'b0;
        end else begin : g_body
            assign in_byte  = cell_byte[j-1];
            assign in_rd    = cell_rd[j-1];
            assign in_clear = i_region_first;
        end

        mvsm_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_shift     (in_acc),
            .i_clear     (in_clear),
            .i_byte      (in_byte),
            .i_readable  (in_rd),
            .i_pat_byte  (pat_byte),
            .i_care_mask (care),
            .o_byte      (cell_byte[j]),
            .o_readable  (cell_rd[j]),
            .o_equal     (cell_eq[j])
        );
    end

    // fill count and region alignment
    always_comb begin
        fill_base  = i_region_first ? '0 : r_fill;
        align_base = i_region_first ? '0 : r_align;
        align_step = 8'(align_base) + 8'd1;
        n_fill     = (int'(fill_base) < MAXB) ? fill_base + 1'b1 : fill_base;
        if (len == '0) n_align = align_base;
        else if (align_step >= 8'(len)) n_align = '0;
        else n_align = mvsm_pkg::ALIGN_W'(align_step);
    end

    assign n_eval_valid = in_acc || o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill       <= '0;
            r_align      <= '0;
            r_eval_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_eval_valid <= n_eval_valid;
            if (in_acc) begin
                r_fill  <= n_fill;
                r_align <= n_align;
            end
            if (out_load) r_out_valid <= 1'b1;
            else if (!i_out_stall) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) r_addr <= i_byte_address;
        if (out_load) begin
            r_hit_address <= r_addr - (mvsm_pkg::ADDRESS_BITS'(len) - 1'b1);
            r_hit_value   <= ev_value;
        end
    end

    assign eval_cfg = '{kind: r_value_kind, mode: r_scan_mode, len: len,
                        low: r_low_value, high: r_high_value};

    mvsm_eval u_eval (
        .i_cfg          (eval_cfg),
        .i_win_bytes    (cell_byte),
        .i_win_readable (cell_rd),
        .i_cell_equal   (cell_eq),
        .i_fill         (r_fill),
        .i_align        (r_align),
        .o_hit          (ev_hit),
        .o_value        (ev_value)
    );

    assign o_out_valid   = r_out_valid;
    assign o_hit_address = r_hit_address;
    assign o_hit_value   = r_hit_value;

    `MVSM_ASSERT_NEXT(a_accept_evaluates, in_acc, r_eval_valid, "accepted item not evaluated")
    `MVSM_ASSERT_NEXT(a_region_restart, in_acc && i_region_first, r_fill == mvsm_pkg::FILL_W'(1), "region start did not restart fill")
    `MVSM_ASSERT_SAME(a_fill_bound, 1'b1, int'(r_fill) <= MAXB, "fill count past window depth")
    `MVSM_ASSERT_SAME(a_out_from_eval, $rose(o_out_valid), $past(r_eval_valid && ev_hit), "result without a hit")

endmodule
